// ===== sv/idab_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// idab_pkg
// Types, codes and default sizes for the bitmap ID allocator.
// ----------------------------------------------------------------------------
package idab_pkg;

  localparam int ID_BITS_DEF     = 16;
  localparam int WORD_BITS_DEF   = 64;
  localparam int STACK_DEPTH_DEF = 4096;
  localparam int ID_W            = 16;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_RESERVE = 2'd2,
    OP_CLEAR   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_REJECT  = 2'd1,
    ST_EXHAUST = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_POP,
    S_POPW,
    S_CHK,
    S_CNT,
    S_RD,
    S_MOD,
    S_DONE
  } state_t;

  typedef struct packed {
    op_t             operation;
    logic [ID_W-1:0] id;
  } req_t;

  typedef struct packed {
    logic [ID_W-1:0] new_id;
    status_t         status;
  } rsp_t;

endpackage
`default_nettype wire

// ===== sv/idab_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// idab_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module idab_ram #(
  parameter int W = 16,
  parameter int D = 16
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic      [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== sv/id_allocator_bitmap_free_stack.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// id_allocator_bitmap_free_stack
// Free and reserve: read the bitmap word (S_RD), modify and write it (S_MOD),
// respond (S_DONE); an ID out of range is rejected at once. Allocate pops
// the free stack (S_POP, S_POPW, S_CHK), skipping stale entries, then scans the
// counter (S_CNT, S_CHK), one bitmap read per candidate, until exhausted. Clear
// reruns the clearing pass and replies. One request at a time; a response stall
// also holds off the next. After reset, a clearing pass zeroes all MAP_WORDS
// words (1024 at defaults), one word a cycle, with req_stall high throughout.
// ----------------------------------------------------------------------------
module id_allocator_bitmap_free_stack #(
  parameter int ID_BITS     = idab_pkg::ID_BITS_DEF,
  parameter int WORD_BITS   = idab_pkg::WORD_BITS_DEF,
  parameter int STACK_DEPTH = idab_pkg::STACK_DEPTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_stall,
  input  wire idab_pkg::req_t req,
  output logic                rsp_valid,
  input  wire logic           rsp_stall,
  output idab_pkg::rsp_t      rsp
);

  import idab_pkg::*;

  // bitmap words are WORD_BITS rounded up to a power of two
  localparam int LB        = $clog2(WORD_BITS);
  localparam int LANE      = 1 << LB;
  localparam int MW        = ID_BITS - LB;
  localparam int MAP_WORDS = 1 << MW;
  localparam int VW        = ((ID_BITS > ID_W) ? ID_BITS : ID_W) + 1;
  localparam int SAW       = $clog2(STACK_DEPTH);
  localparam int CNTW      = $clog2(STACK_DEPTH + 1);

  state_t state, state_next;

  op_t              op, op_next;
  logic [ID_BITS-1:0] vid, vid_next;
  logic [ID_BITS-1:0] cand, cand_next;
  logic [CNTW-1:0]    count, count_next;
  logic [ID_BITS:0]   counter, counter_next;
  logic [MW-1:0]      ptr, ptr_next;
  logic               clr_reply, clr_reply_next;
  logic [ID_W-1:0]    res_id, res_id_next;
  status_t            res_status, res_status_next;
  logic               rsp_valid_next;
  rsp_t               rsp_next;

  logic            map_we;
  logic [MW-1:0]   map_waddr, map_raddr;
  logic [LANE-1:0] map_wdata, map_rdata;
  logic            stk_we;
  logic [SAW-1:0]  stk_waddr, stk_raddr;
  logic [ID_BITS-1:0] stk_wdata, stk_rdata;

  logic [VW-1:0]   v_ext;
  logic            v_oob;
  logic            accept;
  logic            slot_free;
  logic [LANE-1:0] cand_mask, vid_mask;
  logic            cand_used, vid_used;

  assign v_ext     = VW'(req.id);
  assign v_oob     = v_ext >= (VW'(1) << ID_BITS);
  assign accept    = req_valid && !req_stall;
  assign req_stall = (state != S_IDLE);
  assign slot_free = !rsp_valid || !rsp_stall;
  assign cand_mask = LANE'(1) << cand[LB-1:0];
  assign vid_mask  = LANE'(1) << vid[LB-1:0];
  assign cand_used = |(map_rdata & cand_mask);
  assign vid_used  = |(map_rdata & vid_mask);

  idab_ram #(.W(LANE), .D(MAP_WORDS)) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  idab_ram #(.W(ID_BITS), .D(STACK_DEPTH)) u_stk (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLR: begin
        if (ptr == {MW{1'b1}}) begin
          state_next = clr_reply ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          case (req.operation)
            OP_ALLOC:   state_next = (count != '0) ? S_POP : S_CNT;
            OP_FREE,
            OP_RESERVE: state_next = v_oob ? S_DONE : S_RD;
            default:    state_next = S_CLR;
          endcase
        end
      end
      S_POP:  state_next = S_POPW;
      S_POPW: state_next = S_CHK;
      S_CHK: begin
        if (!cand_used) begin
          state_next = S_DONE;
        end else begin
          state_next = (count != '0) ? S_POP : S_CNT;
        end
      end
      S_CNT:  state_next = (counter < (ID_BITS+1)'(MAP_WORDS * LANE)) ? S_CHK : S_DONE;
      S_RD:   state_next = S_MOD;
      S_MOD:  state_next = S_DONE;
      S_DONE: state_next = slot_free ? S_IDLE : S_DONE;
      default: state_next = S_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    op_next         = op;
    vid_next        = vid;
    cand_next       = cand;
    count_next      = count;
    counter_next    = counter;
    ptr_next        = ptr;
    clr_reply_next  = clr_reply;
    res_id_next     = res_id;
    res_status_next = res_status;
    map_we          = 1'b0;
    map_waddr       = ptr;
    map_wdata       = '0;
    map_raddr       = vid[ID_BITS-1:LB];
    stk_we          = 1'b0;
    stk_waddr       = count[SAW-1:0];
    stk_wdata       = vid;
    stk_raddr       = SAW'(count - 1'b1);
    rsp_valid_next  = rsp_valid && rsp_stall;
    rsp_next        = rsp;
    case (state)
      S_CLR: begin
        map_we   = 1'b1;
        ptr_next = ptr + 1'b1;
      end
      S_IDLE: begin
        if (accept) begin
          op_next         = req.operation;
          vid_next        = v_ext[ID_BITS-1:0];
          res_id_next     = '0;
          res_status_next = (v_oob && (req.operation == OP_FREE ||
                                       req.operation == OP_RESERVE)) ? ST_REJECT : ST_OK;
          if (req.operation == OP_CLEAR) begin
            count_next     = '0;
            counter_next   = (ID_BITS+1)'(1);
            ptr_next       = '0;
            clr_reply_next = 1'b1;
          end
        end
      end
      S_POP: begin
        count_next = count - 1'b1;
      end
      S_POPW: begin
        map_raddr = stk_rdata[ID_BITS-1:LB];
        cand_next = stk_rdata;
      end
      S_CHK: begin
        if (!cand_used) begin
          map_we          = 1'b1;
          map_waddr       = cand[ID_BITS-1:LB];
          map_wdata       = map_rdata | cand_mask;
          res_id_next     = ID_W'(cand);
          res_status_next = ST_OK;
        end
      end
      S_CNT: begin
        if (counter < (ID_BITS+1)'(MAP_WORDS * LANE)) begin
          map_raddr    = counter[ID_BITS-1:LB];
          cand_next    = counter[ID_BITS-1:0];
          counter_next = counter + 1'b1;
        end else begin
          res_id_next     = '0;
          res_status_next = ST_EXHAUST;
        end
      end
      S_MOD: begin
        map_waddr = vid[ID_BITS-1:LB];
        if (op == OP_FREE) begin
          if (!vid_used) begin
            res_status_next = ST_REJECT;
          end else begin
            map_we    = 1'b1;
            map_wdata = map_rdata & ~vid_mask;
            // drop the push when the stack is full
            if (count < CNTW'(STACK_DEPTH)) begin
              stk_we     = 1'b1;
              count_next = count + 1'b1;
            end
          end
        end else begin
          if (vid_used) begin
            res_status_next = ST_REJECT;
          end else begin
            map_we    = 1'b1;
            map_wdata = map_rdata | vid_mask;
          end
        end
      end
      S_DONE: begin
        if (slot_free) begin
          rsp_valid_next  = 1'b1;
          rsp_next.new_id = res_id;
          rsp_next.status = res_status;
          clr_reply_next  = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      count     <= '0;
      counter   <= (ID_BITS+1)'(1);
      ptr       <= '0;
      clr_reply <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      counter   <= counter_next;
      ptr       <= ptr_next;
      clr_reply <= clr_reply_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    op         <= op_next;
    vid        <= vid_next;
    cand       <= cand_next;
    res_id     <= res_id_next;
    res_status <= res_status_next;
    rsp        <= rsp_next;
  end

endmodule
`default_nettype wire

// ===== sv/idab_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// idab_checker
// Port-level checks for the ID allocator, bound to the top level.
// ----------------------------------------------------------------------------
module idab_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           req_valid,
  input wire logic           req_stall,
  input wire idab_pkg::req_t req,
  input wire logic           rsp_valid,
  input wire logic           rsp_stall,
  input wire idab_pkg::rsp_t rsp
);

  import idab_pkg::*;

  // one request in flight: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("request accepted while previous one in flight");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.status == ST_OK || rsp.status == ST_REJECT ||
                   rsp.status == ST_EXHAUST))
    else $error("undefined status code");

  a_failed_zero_id: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status != ST_OK) |-> (rsp.new_id == '0))
    else $error("failed request carries nonzero id");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
    else $error("stalled response changed");

endmodule

bind id_allocator_bitmap_free_stack idab_checker u_idab_checker (.*);
`default_nettype wire
